### rtl/ght_pkg.sv
// ght_pkg: command, status and state codes for the generational handle table.
// No dependencies.
`timescale 1ns / 1ps
package ght_pkg;
    typedef enum logic [2:0] {
        CMD_CREATE   = 3'd0,
        CMD_VALIDATE = 3'd1,
        CMD_ACQUIRE  = 3'd2,
        CMD_RELEASE  = 3'd3,
        CMD_DESTROY  = 3'd4,
        CMD_RSVD5    = 3'd5,
        CMD_RSVD6    = 3'd6,
        CMD_RSVD7    = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK               = 3'd0,
        ST_BAD_TYPE         = 3'd1,
        ST_FULL             = 3'd2,
        ST_BAD_HANDLE       = 3'd3,
        ST_GEN_MISMATCH     = 3'd4,
        ST_REF_OVERFLOW     = 3'd5,
        ST_NOT_ACQUIRED     = 3'd6,
        ST_STILL_REFERENCED = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_TSCAN, S_READ, S_EXEC, S_OUT
    } t_state;

    localparam int unsigned REG_OBJ_CAP  = 0;
    localparam int unsigned REG_TYPE_CAP = 1;
endpackage

### rtl/generational_handle_table_unit.sv
// generational_handle_table_unit: top level of the handle table.
// Depends on ght_pkg. Slot state lives in one memory, types in a second.
`timescale 1ns / 1ps
// Usage:
//  Requests enter on s_axis (tdata = cmd, slot, generation, type_id,
//  initial_refs from bit 0 up). Each request gives one result on m_axis
//  (status, out_slot, out_generation, alive_count, types_known and six
//  32-bit counters, from bit 0 up).
//  Config: i_cfg_we / i_cfg_index / i_cfg_data; 0 object capacity,
//  1 type capacity, both clamped to the parameters. Write only when idle.
//  Timing: after a validate/acquire/release/destroy request is taken, the
//  block reads the slot word, executes and writes back, tallies the status
//  counters and presents the result; the next request is taken in the cycle
//  after the result is taken. Create first scans free slots one per cycle
//  through the active-flag vector and then the type table one entry per
//  cycle through its memory port, then reads, executes, tallies and presents.
//  One request at a time; the result register holds the result while the
//  receiver stalls and tready stays low until it is taken.
//  Reset: active flags cleared in flip-flops; slot words read as zero
//  while not valid, so no clearing pass is needed. Counters zero.
module generational_handle_table_unit #(
    parameter int SLOT_COUNT = 64,
    parameter int TYPE_COUNT = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[2:0] slot[8:3] generation[40:9] type_id[56:41] initial_refs[88:57]
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0] out_slot[8:3] out_generation[40:9] alive_count[47:41]
    // types_known[52:48] referenced_total[84:53] created[116:85]
    // destroyed[148:117] released[180:149] failed[212:181] accepted[244:213]
    output logic [247:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [6:0]   i_cfg_data
);
    import ght_pkg::*;
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

    // slot word: {refcount, type, generation}
    logic [79:0] r_mem [SLOT_COUNT];
    logic [15:0] r_tmem [TYPE_COUNT];
    logic [SLOT_COUNT-1:0] r_active, r_wr;   // r_wr: entry ever written

    t_state r_state, n_state;
    logic [6:0]  r_ocap;
    logic [4:0]  r_tcap;
    logic [6:0]  r_alive;
    logic [4:0]  r_tcnt;
    logic [31:0] r_cnt [6];
    logic [2:0]  r_cmd;
    logic [5:0]  r_slot_in;
    logic [31:0] r_gen, r_refs;
    logic [15:0] r_type;
    logic [SW:0] r_idx;
    logic [4:0]  r_tidx;
    logic        r_tfound;
    logic [79:0] r_rd;
    logic [15:0] r_trd;
    logic        r_trd_v;
    logic [2:0]  r_st;
    logic [5:0]  r_oslot;
    logic [31:0] r_ogen;
    logic        r_tally;    // first output cycle: status counters update

    logic [79:0] w_word;
    logic [31:0] w_sgen, w_sref;
    logic [15:0] w_styp;
    logic        w_wr_v;
    logic [SW-1:0] w_addr;
    logic        w_tmatch;

    assign w_addr = r_idx[SW-1:0];
    assign w_word = r_wr[w_addr] ? r_rd : '0;
    assign w_sgen = w_word[31:0];
    assign w_styp = w_word[47:32];
    assign w_sref = w_word[79:48];
    assign w_wr_v = r_wr[w_addr];
    // r_trd holds entry r_tidx-1; only entries below the type count are live
    assign w_tmatch = r_trd_v && (r_tidx <= r_tcnt) && (r_trd == r_type);

    logic [6:0] w_ocap_lim;
    assign w_ocap_lim = (7'(SLOT_COUNT) < r_ocap) ? 7'(SLOT_COUNT) : r_ocap;

    always_ff @(posedge i_clk) begin
        r_rd  <= r_mem[w_addr];
        r_trd <= r_tmem[r_tidx[TW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ocap   <= 7'(SLOT_COUNT > 64 ? 64 : SLOT_COUNT);
            r_tcap   <= 5'(TYPE_COUNT > 16 ? 16 : TYPE_COUNT);
            r_active <= '0;
            r_wr     <= '0;
            r_alive  <= '0;
            r_tcnt   <= '0;
            r_tally  <= 1'b0;
            for (int k = 0; k < 6; k++) r_cnt[k] <= '0;
        end else begin
            r_state <= n_state;
            r_tally <= (r_state == S_EXEC);
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(REG_OBJ_CAP))
                    r_ocap <= (i_cfg_data > 7'(SLOT_COUNT)) ? 7'(SLOT_COUNT) : i_cfg_data;
                else
                    r_tcap <= (i_cfg_data[4:0] > 5'(TYPE_COUNT)) ? 5'(TYPE_COUNT)
                              : i_cfg_data[4:0];
            end
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_cmd     <= s_axis_tdata[2:0];
                    r_slot_in <= s_axis_tdata[8:3];
                    r_gen     <= s_axis_tdata[40:9];
                    r_type    <= s_axis_tdata[56:41];
                    r_refs    <= s_axis_tdata[88:57];
                    r_idx     <= (s_axis_tdata[2:0] == CMD_CREATE) ? '0
                                 : (SW+1)'(s_axis_tdata[8:3]);
                    r_tidx    <= '0;
                    r_tfound  <= 1'b0;
                    r_trd_v   <= 1'b0;
                    r_oslot   <= '0;
                    r_ogen    <= '0;
                end
                S_SCAN: if (!(r_idx < (SW+1)'(w_ocap_lim) && !r_active[w_addr]))
                    r_idx <= r_idx + 1'b1;
                S_TSCAN: begin
                    // one table entry per cycle; r_trd is entry r_tidx-1
                    if (w_tmatch) r_tfound <= 1'b1;
                    r_trd_v <= 1'b1;
                    r_tidx  <= r_tidx + 1'b1;
                end
                S_READ: ;
                S_EXEC: begin
                    if (r_cmd == CMD_CREATE) begin
                        if (r_type == 16'd0) r_st <= ST_BAD_TYPE;
                        else if (r_alive >= w_ocap_lim ||
                                 r_idx >= (SW+1)'(w_ocap_lim)) r_st <= ST_FULL;
                        else if (!r_tfound && (r_tcnt >= r_tcap ||
                                 r_tcnt >= 5'(TYPE_COUNT))) r_st <= ST_FULL;
                        else begin
                            r_st <= ST_OK;
                            if (!r_tfound) begin
                                r_tmem[r_tcnt[TW-1:0]] <= r_type;
                                r_tcnt <= r_tcnt + 1'b1;
                            end
                            r_mem[w_addr] <= {r_refs, r_type,
                                              (w_sgen == 0) ? 32'd1 : w_sgen};
                            r_wr[w_addr]     <= 1'b1;
                            r_active[w_addr] <= 1'b1;
                            r_alive <= r_alive + 1'b1;
                            r_cnt[1] <= r_cnt[1] + 1'b1;
                            r_cnt[0] <= r_cnt[0] + r_refs;
                            r_oslot <= 6'(r_idx);
                            r_ogen  <= (w_sgen == 0) ? 32'd1 : w_sgen;
                        end
                    end else if (r_cmd > CMD_DESTROY) r_st <= ST_BAD_HANDLE;
                    else if (r_gen == 0 || r_idx >= (SW+1)'(w_ocap_lim) || !w_wr_v ||
                             w_sgen == 0)
                        r_st <= ST_BAD_HANDLE;
                    else if (w_sgen != r_gen) r_st <= ST_GEN_MISMATCH;
                    else if (!r_active[w_addr]) r_st <= ST_BAD_HANDLE;
                    else if (r_cmd == CMD_ACQUIRE) begin
                        if (w_sref == 32'hFFFF_FFFF) r_st <= ST_REF_OVERFLOW;
                        else begin
                            r_st <= ST_OK;
                            r_mem[w_addr] <= {w_sref + 32'd1, w_styp, w_sgen};
                            r_cnt[0] <= r_cnt[0] + 1'b1;
                        end
                    end else if (r_cmd == CMD_RELEASE) begin
                        if (w_sref == 0) r_st <= ST_NOT_ACQUIRED;
                        else begin
                            r_st <= ST_OK;
                            r_mem[w_addr] <= {w_sref - 32'd1, w_styp, w_sgen};
                            r_cnt[0] <= r_cnt[0] - 1'b1;
                            r_cnt[3] <= r_cnt[3] + 1'b1;
                        end
                    end else if (r_cmd == CMD_DESTROY) begin
                        if (w_sref != 0) r_st <= ST_STILL_REFERENCED;
                        else begin
                            r_st <= ST_OK;
                            r_mem[w_addr] <= {32'd0, 16'd0,
                                (w_sgen == 32'hFFFF_FFFF) ? 32'd1 : w_sgen + 32'd1};
                            r_active[w_addr] <= 1'b0;
                            r_alive <= r_alive - 1'b1;
                            r_cnt[2] <= r_cnt[2] + 1'b1;
                        end
                    end else r_st <= ST_OK;   // validate of a live handle
                end
                S_OUT: ;
                default: ;
            endcase
            // accepted/failed counters update in the first output cycle
            if (r_tally) begin
                if (r_st == ST_OK) r_cnt[5] <= r_cnt[5] + 1'b1;
                else r_cnt[4] <= r_cnt[4] + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        if (!i_rst_n) n_state = S_IDLE;
        else unique case (r_state)
            S_IDLE:  if (s_axis_tvalid)
                n_state = (s_axis_tdata[2:0] == CMD_CREATE) ? S_SCAN : S_READ;
            S_SCAN:  if (r_idx >= (SW+1)'(w_ocap_lim) || !r_active[w_addr])
                n_state = S_TSCAN;
            S_TSCAN: if (r_tidx > r_tcnt || r_tidx > 5'(TYPE_COUNT - 1) || w_tmatch)
                n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = S_OUT;
            S_OUT:   if (m_axis_tready && !r_tally) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT) && !r_tally;
    assign m_axis_tdata  = {3'd0, r_cnt[5], r_cnt[4], r_cnt[3], r_cnt[2], r_cnt[1],
                            r_cnt[0], r_tcnt, r_alive, r_ogen, r_oslot, r_st};

    property p_alive; @(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> $countones(r_active) == int'(r_alive); endproperty
    assert property (p_alive) else $error("alive");
    property p_one; @(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready; endproperty
    assert property (p_one) else $error("overlap");
    property p_tc; @(posedge i_clk) disable iff (!i_rst_n)
        r_tcnt <= 5'(TYPE_COUNT); endproperty
    assert property (p_tc) else $error("types");
endmodule

### test/generational_handle_table_unit_test.sv
// Self-checking bench for generational_handle_table_unit: drives handle table
// requests, predicts every result in a local model, compares all fields.
// Depends on ght_pkg and the handle table RTL.
`timescale 1ns / 1ps
module generational_handle_table_unit_test;
    import ght_pkg::*;

    typedef struct packed {
        logic [31:0] initial_refs;
        logic [15:0] type_id;
        logic [31:0] generation;
        logic [5:0]  slot;
        t_cmd        cmd;
    } t_request;

    typedef struct packed {
        logic [31:0] accepted;
        logic [31:0] failed;
        logic [31:0] released;
        logic [31:0] destroyed;
        logic [31:0] created;
        logic [31:0] referenced;
        logic [4:0]  types_known;
        logic [6:0]  alive;
        logic [31:0] out_gen;
        logic [5:0]  out_slot;
        t_status     status;
    } t_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;   // cmd, slot, generation, type_id, initial_refs
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [247:0] m_axis_tdata;   // status, out_slot, out_generation, alive,
                                  // types_known, six counters
    logic         i_cfg_we;
    logic         i_cfg_index;
    logic [6:0]   i_cfg_data;

    generational_handle_table_unit dut (.*);

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------- table model ----------------
    int unsigned  obj_cap, type_cap;
    bit           m_active [64];
    logic [31:0]  m_gen [64];
    logic [31:0]  m_refs [64];
    logic [15:0]  m_types [16];
    int unsigned  m_type_cnt, m_alive;
    logic [31:0]  c_ref, c_cre, c_des, c_rel, c_fail, c_acc;

    t_request     pending_requests[$];
    t_result      expected_results[$];
    int           fail_cnt;
    bit           stim_done;

    function automatic t_status check_handle(logic [5:0] s, logic [31:0] g);
        if (g == 0) return ST_BAD_HANDLE;
        if (s >= obj_cap) return ST_BAD_HANDLE;
        if (m_gen[s] == 0) return ST_BAD_HANDLE;
        if (m_gen[s] != g) return ST_GEN_MISMATCH;
        if (!m_active[s]) return ST_BAD_HANDLE;
        return ST_OK;
    endfunction

    function automatic t_result apply_request(t_request r);
        t_result res;
        t_status st;
        int      free_slot;
        bit      known;
        res = '0;
        st = ST_OK;
        if (r.cmd == CMD_CREATE) begin
            free_slot = -1;
            known = 0;
            if (r.type_id == 0) st = ST_BAD_TYPE;
            else if (m_alive >= obj_cap) st = ST_FULL;
            else begin
                for (int i = 0; i < obj_cap; i++)
                    if (!m_active[i] && free_slot < 0) free_slot = i;
                for (int i = 0; i < m_type_cnt; i++)
                    if (m_types[i] == r.type_id) known = 1;
                if (free_slot < 0) st = ST_FULL;
                else if (!known && m_type_cnt >= type_cap) st = ST_FULL;
            end
            if (st == ST_OK) begin
                if (!known) begin
                    m_types[m_type_cnt] = r.type_id;
                    m_type_cnt++;
                end
                if (m_gen[free_slot] == 0) m_gen[free_slot] = 1;
                m_refs[free_slot] = r.initial_refs;
                m_active[free_slot] = 1;
                m_alive++;
                c_cre++;
                c_ref += r.initial_refs;
                res.out_slot = free_slot[5:0];
                res.out_gen = m_gen[free_slot];
            end
        end else if (r.cmd <= CMD_DESTROY) begin
            st = check_handle(r.slot, r.generation);
            if (st == ST_OK) begin
                case (r.cmd)
                    CMD_ACQUIRE: begin
                        if (m_refs[r.slot] == 32'hFFFF_FFFF) st = ST_REF_OVERFLOW;
                        else begin
                            m_refs[r.slot]++;
                            c_ref++;
                        end
                    end
                    CMD_RELEASE: begin
                        if (m_refs[r.slot] == 0) st = ST_NOT_ACQUIRED;
                        else begin
                            m_refs[r.slot]--;
                            c_ref--;
                            c_rel++;
                        end
                    end
                    CMD_DESTROY: begin
                        if (m_refs[r.slot] != 0) st = ST_STILL_REFERENCED;
                        else begin
                            m_active[r.slot] = 0;
                            m_gen[r.slot] = (m_gen[r.slot] == 32'hFFFF_FFFF) ? 32'd1
                                            : m_gen[r.slot] + 32'd1;
                            m_alive--;
                            c_des++;
                        end
                    end
                    default: ;
                endcase
            end
        end else begin
            st = ST_BAD_HANDLE;
        end
        if (st == ST_OK) c_acc++;
        else c_fail++;
        res.status = st;
        res.alive = m_alive[6:0];
        res.types_known = m_type_cnt[4:0];
        res.referenced = c_ref;
        res.created = c_cre;
        res.destroyed = c_des;
        res.released = c_rel;
        res.failed = c_fail;
        res.accepted = c_acc;
        return res;
    endfunction

    // ---------------- driver ----------------
    int drv_wait;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            drv_wait <= 0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(apply_request(pending_requests.pop_front()));
            s_axis_tvalid <= 1'b0;
            drv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        end else if (!s_axis_tvalid) begin
            if (drv_wait > 0) drv_wait <= drv_wait - 1;
            else if (pending_requests.size() > 0) begin
                s_axis_tdata <= 96'(pending_requests[0]);
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // ---------------- monitor ----------------
    int mon_wait;
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            mon_wait <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[244:0];
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    fail_cnt++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        fail_cnt++;
                    end
                    if (got.out_slot !== want.out_slot) begin
                        $error("out_slot exp %0d got %0d", want.out_slot, got.out_slot);
                        fail_cnt++;
                    end
                    if (got.out_gen !== want.out_gen) begin
                        $error("out_generation exp %0h got %0h", want.out_gen, got.out_gen);
                        fail_cnt++;
                    end
                    if (got.alive !== want.alive) begin
                        $error("alive_count exp %0d got %0d", want.alive, got.alive);
                        fail_cnt++;
                    end
                    if (got.types_known !== want.types_known) begin
                        $error("types_known exp %0d got %0d", want.types_known,
                               got.types_known);
                        fail_cnt++;
                    end
                    if (got.referenced !== want.referenced) begin
                        $error("referenced_total exp %0h got %0h", want.referenced,
                               got.referenced);
                        fail_cnt++;
                    end
                    if (got.created !== want.created) begin
                        $error("created_count exp %0d got %0d", want.created, got.created);
                        fail_cnt++;
                    end
                    if (got.destroyed !== want.destroyed) begin
                        $error("destroyed_count exp %0d got %0d", want.destroyed,
                               got.destroyed);
                        fail_cnt++;
                    end
                    if (got.released !== want.released) begin
                        $error("released_count exp %0d got %0d", want.released,
                               got.released);
                        fail_cnt++;
                    end
                    if (got.failed !== want.failed) begin
                        $error("failed_count exp %0d got %0d", want.failed, got.failed);
                        fail_cnt++;
                    end
                    if (got.accepted !== want.accepted) begin
                        $error("accepted_count exp %0d got %0d", want.accepted,
                               got.accepted);
                        fail_cnt++;
                    end
                end
            end
            // stall draw per result; some long runs with no stall at all
            if (m_axis_tready && m_axis_tvalid) begin
                m_axis_tready <= 1'b0;
                mon_wait <= (stim_done || $urandom_range(0, 3) == 0) ? 0
                            : $urandom_range(0, 19);
            end else if (!m_axis_tready) begin
                if (mon_wait > 0) mon_wait <= mon_wait - 1;
                else m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_req(t_cmd c, logic [5:0] s, logic [31:0] g, logic [15:0] t,
                            logic [31:0] refs);
        t_request r;
        r.cmd = c;
        r.slot = s;
        r.generation = g;
        r.type_id = t;
        r.initial_refs = refs;
        pending_requests.push_back(r);
    endtask

    // wait for all traffic to finish, then let the block settle
    task automatic drain();
        while (pending_requests.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(int unsigned idx, logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= 1'(idx);
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_OBJ_CAP) obj_cap = (val > 64) ? 64 : val;
        else type_cap = (val[4:0] > 16) ? 16 : val[4:0];
    endtask

    // Mostly legal handles drawn from the model, with stale and garbage ones mixed in
    task automatic random_phase(int n, int type_span);
        t_cmd        c;
        logic [5:0]  s;
        logic [31:0] g;
        int          pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            s = 6'($urandom_range(0, 63));
            if (pick < 3) c = t_cmd'($urandom_range(5, 7));
            else if (pick < 30) c = CMD_CREATE;
            else c = t_cmd'($urandom_range(1, 4));
            case ($urandom_range(0, 9))
                0: g = $urandom;
                1: g = 0;
                2: g = m_gen[s] + 1;
                default: g = m_gen[s];
            endcase
            push_req(c, s, g,
                     ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, type_span)),
                     ($urandom_range(0, 9) == 0) ? $urandom
                                                 : 32'($urandom_range(0, 2)));
            // keep the model of generations usable: wait for the queue to drain often
            if (pending_requests.size() > 4) wait (pending_requests.size() < 2);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        s_axis_tdata = '0;
        fail_cnt = 0;
        stim_done = 0;
        obj_cap = 64;
        type_cap = 16;
        m_type_cnt = 0;
        m_alive = 0;
        {c_ref, c_cre, c_des, c_rel, c_fail, c_acc} = '0;
        for (int i = 0; i < 64; i++) begin
            m_active[i] = 0;
            m_gen[i] = 0;
            m_refs[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corner cases on a fresh table
        push_req(CMD_CREATE, 0, 0, 16'h0000, 5);               // bad type
        push_req(CMD_VALIDATE, 0, 1, 0, 0);                    // never created slot
        push_req(CMD_CREATE, 63, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_req(CMD_ACQUIRE, 0, 1, 0, 0);                     // ref overflow
        push_req(CMD_VALIDATE, 0, 0, 0, 0);                    // zero generation
        push_req(CMD_VALIDATE, 0, 2, 0, 0);                    // generation mismatch
        push_req(CMD_CREATE, 0, 0, 16'h0001, 0);
        push_req(CMD_RELEASE, 1, 1, 0, 0);                     // not acquired
        push_req(CMD_ACQUIRE, 1, 1, 0, 0);
        push_req(CMD_DESTROY, 1, 1, 0, 0);                     // still referenced
        push_req(CMD_RELEASE, 1, 1, 0, 0);
        push_req(CMD_DESTROY, 1, 1, 0, 0);
        push_req(CMD_VALIDATE, 1, 2, 0, 0);                    // inactive slot
        push_req(CMD_CREATE, 0, 0, 16'h0001, 1);               // reuses slot 1, gen 2
        push_req(CMD_RSVD5, 63, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_req(CMD_RSVD6, 0, 0, 0, 0);
        push_req(CMD_RSVD7, 0, 0, 0, 0);
        push_req(CMD_VALIDATE, 63, 1, 0, 0);
        drain();  // sender holds off until every result is in

        // small capacities: full table, full type table, out of range slots
        write_reg(REG_OBJ_CAP, 7'd2);
        write_reg(REG_TYPE_CAP, 5'd2);
        push_req(CMD_CREATE, 0, 0, 16'h0007, 0);               // full
        push_req(CMD_VALIDATE, 1, 2, 0, 0);
        push_req(CMD_VALIDATE, 5, 1, 0, 0);                    // beyond capacity
        random_phase(300, 4);
        drain();

        write_reg(REG_OBJ_CAP, 7'd0);
        write_reg(REG_TYPE_CAP, 5'd0);
        random_phase(40, 4);
        drain();

        write_reg(REG_OBJ_CAP, 7'h7F);                         // clamps to 64
        write_reg(REG_TYPE_CAP, 5'h1F);                        // clamps to 16
        random_phase(800, 24);
        drain();

        write_reg(REG_OBJ_CAP, 7'd9);
        write_reg(REG_TYPE_CAP, 5'd5);
        random_phase(400, 8);
        drain();

        write_reg(REG_OBJ_CAP, 7'd64);
        write_reg(REG_TYPE_CAP, 5'd16);
        random_phase(500, 40);
        stim_done = 1;
        drain();

        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
